@@ design/qbr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qbr_pkg;

    // default widths of the interval ends, fraction and coefficients
    localparam int X_WIDTH_DEF    = 44;
    localparam int FRAC_BITS_DEF  = 24;
    localparam int COEF_WIDTH_DEF = 16;

    // width of one multiplier digit taken from the abscissa per cycle
    localparam int CHUNK_W = 16;

    // configuration register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CONST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LINEAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SQUARE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 2'd3;

    // register reset values
    localparam int COEF_CONST_RST  = 0;
    localparam int COEF_LINEAR_RST = 2;
    localparam int COEF_SQUARE_RST = 3;
    localparam int TOLERANCE_RST   = 168;

    // status of one polynomial evaluation, done is a one-cycle pulse
    typedef struct packed {
        logic done;
        logic neg;
        logic zero;
    } qbr_eval_status_t;

endpackage

`default_nettype wire

@@ design/qbr_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// input channel: one search interval per beat
interface qbr_in_if
    import qbr_pkg::*;
#(
    parameter int X_WIDTH = X_WIDTH_DEF
) ();
    logic               valid;
    logic               ready;
    logic [X_WIDTH-1:0] interval_low;
    logic [X_WIDTH-1:0] interval_high;

    modport source (output valid, output interval_low, output interval_high, input ready);
    modport sink   (input valid, input interval_low, input interval_high, output ready);
endinterface

// output channel: one root per beat
interface qbr_out_if
    import qbr_pkg::*;
#(
    parameter int X_WIDTH = X_WIDTH_DEF
) ();
    logic               valid;
    logic               ready;
    logic [X_WIDTH-1:0] root;
    logic               exact_zero;

    modport source (output valid, output root, output exact_zero, input ready);
    modport sink   (input valid, input root, input exact_zero, output ready);
endinterface

`default_nettype wire

@@ design/qbr_quad_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none

// exact sign of c0*2^(2F) + c1*x*2^F + c2*x*x, Horner form on one
// multiply-accumulate unit that takes one 16-bit digit of x per cycle
module qbr_quad_eval
    import qbr_pkg::*;
#(
    parameter int X_WIDTH    = X_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [X_WIDTH-1:0]    x,
    input  wire logic [COEF_WIDTH-1:0] coef_const,
    input  wire logic [COEF_WIDTH-1:0] coef_linear,
    input  wire logic [COEF_WIDTH-1:0] coef_square,
    output qbr_eval_status_t           status
);

    localparam int NCH   = (X_WIDTH + CHUNK_W - 1) / CHUNK_W;
    localparam int XEW   = NCH * CHUNK_W;
    localparam int CNT_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int TW    = ((X_WIDTH > FRAC_BITS) ? X_WIDTH : FRAC_BITS) + COEF_WIDTH + 1;
    localparam int PW    = TW + CHUNK_W + 1;
    localparam int QA    = TW + XEW;
    localparam int QB    = COEF_WIDTH + 2 * FRAC_BITS;
    localparam int QW    = ((QA > QB) ? QA : QB) + 2;

    localparam logic [1:0] EV_IDLE = 2'd0;
    localparam logic [1:0] EV_MUL  = 2'd1;
    localparam logic [1:0] EV_ADD  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic                   phase_reg, phase_next;
    logic                   first_reg, first_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [XEW-1:0]         xs_reg, xs_next;
    logic signed [QW-1:0]   acc_reg, acc_next;
    logic signed [TW-1:0]   t_reg, t_next;
    qbr_eval_status_t       status_reg, status_next;

    logic [XEW-1:0]         x_ext;
    logic [CHUNK_W-1:0]     chunk;
    logic signed [CHUNK_W:0] chunk_s;
    logic signed [TW-1:0]   mcand;
    logic signed [PW-1:0]   prod;
    logic signed [QW-1:0]   acc_base;
    logic signed [QW-1:0]   mac;
    logic signed [QW-1:0]   addend;
    logic signed [QW-1:0]   sum;

    // digit selection, most significant digit first and the only signed one
    assign x_ext   = XEW'($signed(x));
    assign chunk   = xs_reg[XEW-1 -: CHUNK_W];
    assign chunk_s = {first_reg & chunk[CHUNK_W-1], chunk};

    // shared multiply-accumulate: c2 * x first, then t * x
    assign mcand    = phase_reg ? t_reg : TW'($signed(coef_square));
    assign prod     = PW'(mcand) * PW'(chunk_s);
    assign acc_base = first_reg ? '0 : (acc_reg <<< CHUNK_W);
    assign mac      = acc_base + QW'(prod);

    // scaled constant term of the current Horner level
    assign addend = phase_reg ? (QW'($signed(coef_const)) <<< (2 * FRAC_BITS))
                              : (QW'($signed(coef_linear)) <<< FRAC_BITS);
    assign sum    = acc_reg + addend;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        first_next  = first_reg;
        cnt_next    = cnt_reg;
        xs_next     = xs_reg;
        acc_next    = acc_reg;
        t_next      = t_reg;
        status_next = '0;
        case (state_reg)
            EV_IDLE:
            begin
                if (start)
                begin
                    xs_next    = x_ext;
                    cnt_next   = CNT_W'(NCH - 1);
                    phase_next = 1'b0;
                    first_next = 1'b1;
                    state_next = EV_MUL;
                end
            end
            EV_MUL:
            begin
                acc_next   = mac;
                xs_next    = xs_reg << CHUNK_W;
                first_next = 1'b0;
                if (cnt_reg == '0)
                begin
                    state_next = EV_ADD;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            EV_ADD:
            begin
                if (!phase_reg)
                begin
                    t_next     = sum[TW-1:0];
                    phase_next = 1'b1;
                    xs_next    = x_ext;
                    cnt_next   = CNT_W'(NCH - 1);
                    first_next = 1'b1;
                    state_next = EV_MUL;
                end
                else
                begin
                    status_next.done = 1'b1;
                    status_next.neg  = sum[QW-1];
                    status_next.zero = (sum == '0);
                    state_next       = EV_IDLE;
                end
            end
            default:
            begin
                state_next = EV_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= EV_IDLE;
            phase_reg  <= 1'b0;
            first_reg  <= 1'b0;
            cnt_reg    <= '0;
            status_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            first_reg  <= first_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        xs_reg  <= xs_next;
        acc_reg <= acc_next;
        t_reg   <= t_next;
    end

    assign status = status_reg;

endmodule

`default_nettype wire

@@ design/quadratic_bisection_root_top.sv @@
// Bisection root finder for q(x) = c0 + c1*x + c2*x*x over signed fixed-point
// interval ends (Q20.24 by default). q is evaluated exactly; only its sign
// and zero-ness steer the search.
// Input channel in_ch: one beat carries interval_low and interval_high.
// Output channel out_ch: one beat per input beat with root and exact_zero.
// Configuration: cfg_we/cfg_index/cfg_data write coef_const (0), coef_linear
// (1), coef_square (2) and tolerance (3); write only while no search runs.
// Throughput: one search at a time, in_ch.ready is high only when idle.
// Each evaluation of q runs on the shared 16-bit-digit multiply-accumulate
// unit, N = ceil(X_WIDTH/16) digits (3 by default).
// A search first evaluates both ends and tests the interval, then each halving
// step evaluates the midpoint, keeps one half and tests again; a 44-bit
// interval narrowed to a tolerance of k units needs about 44-log2(k) halvings.
// Stall: the result sits in an output register; a new interval is accepted
// while it waits, and a finished search holds until the register frees up.
// Reset: all control clears, configuration registers return to their reset values.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_bisection_root_top
    import qbr_pkg::*;
#(
    parameter int X_WIDTH    = X_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [((X_WIDTH > COEF_WIDTH) ? X_WIDTH : COEF_WIDTH)-1:0] cfg_data,
    qbr_in_if.sink                    in_ch,
    qbr_out_if.source                 out_ch
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;

    localparam logic [1:0] SEL_LO  = 2'd0;
    localparam logic [1:0] SEL_HI  = 2'd1;
    localparam logic [1:0] SEL_MID = 2'd2;

    // configuration registers
    logic [COEF_WIDTH-1:0] coef_const_reg;
    logic [COEF_WIDTH-1:0] coef_linear_reg;
    logic [COEF_WIDTH-1:0] coef_square_reg;
    logic [X_WIDTH-1:0]    tol_reg;

    // search state
    logic [2:0]          state_reg, state_next;
    logic [1:0]          sel_reg, sel_next;
    logic                start_reg, start_next;
    logic [X_WIDTH-1:0]  lo_reg, lo_next;
    logic [X_WIDTH-1:0]  hi_reg, hi_next;
    logic [X_WIDTH-1:0]  mid_reg, mid_next;
    logic                sl_neg_reg, sl_neg_next;
    logic                sl_zero_reg, sl_zero_next;
    logic                sh_zero_reg, sh_zero_next;
    logic                sm_neg_reg, sm_neg_next;
    logic                sm_zero_reg, sm_zero_next;
    logic                out_valid_reg, out_valid_next;
    logic [X_WIDTH-1:0]  root_reg, root_next;
    logic                exact_zero_reg, exact_zero_next;

    logic [X_WIDTH-1:0]  eval_x;
    qbr_eval_status_t    ev_status;
    logic [X_WIDTH:0]    pair_sum;
    logic [X_WIDTH:0]    diff;
    logic [X_WIDTH-1:0]  mid_calc;
    logic [X_WIDTH-1:0]  tol_eff;
    logic                reversed;
    logic                narrow;
    logic                finished;
    logic                opposite;
    logic                out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_const_reg  <= COEF_WIDTH'(COEF_CONST_RST);
            coef_linear_reg <= COEF_WIDTH'(COEF_LINEAR_RST);
            coef_square_reg <= COEF_WIDTH'(COEF_SQUARE_RST);
            tol_reg         <= X_WIDTH'(TOLERANCE_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COEF_CONST:  coef_const_reg  <= cfg_data[COEF_WIDTH-1:0];
                REG_COEF_LINEAR: coef_linear_reg <= cfg_data[COEF_WIDTH-1:0];
                REG_COEF_SQUARE: coef_square_reg <= cfg_data[COEF_WIDTH-1:0];
                REG_TOLERANCE:   tol_reg         <= cfg_data[X_WIDTH-1:0];
                default:         ;
            endcase
        end
    end

    // point under evaluation
    always_comb
    begin
        case (sel_reg)
            SEL_LO:  eval_x = lo_reg;
            SEL_HI:  eval_x = hi_reg;
            default: eval_x = mid_reg;
        endcase
    end

    qbr_quad_eval #(
        .X_WIDTH    (X_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start_reg),
        .x           (eval_x),
        .coef_const  (coef_const_reg),
        .coef_linear (coef_linear_reg),
        .coef_square (coef_square_reg),
        .status      (ev_status)
    );

    // floored midpoint and width test
    assign pair_sum = {lo_reg[X_WIDTH-1], lo_reg} + {hi_reg[X_WIDTH-1], hi_reg};
    assign mid_calc = pair_sum[X_WIDTH:1];
    assign diff     = {hi_reg[X_WIDTH-1], hi_reg} - {lo_reg[X_WIDTH-1], lo_reg};
    assign reversed = diff[X_WIDTH];
    assign tol_eff  = (tol_reg == '0) ? X_WIDTH'(1) : tol_reg;
    assign narrow   = !reversed && (diff[X_WIDTH-1:0] <= tol_eff);
    assign finished = sl_zero_reg || sh_zero_reg || reversed || narrow;

    // strict sign change between low end and midpoint
    assign opposite = (sl_neg_reg && !sm_neg_reg && !sm_zero_reg)
                   || (!sl_neg_reg && !sl_zero_reg && sm_neg_reg);

    assign out_free = !out_valid_reg || out_ch.ready;

    // search sequencer
    always_comb
    begin
        state_next      = state_reg;
        sel_next        = sel_reg;
        start_next      = 1'b0;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        sl_neg_next     = sl_neg_reg;
        sl_zero_next    = sl_zero_reg;
        sh_zero_next    = sh_zero_reg;
        sm_neg_next     = sm_neg_reg;
        sm_zero_next    = sm_zero_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        root_next       = root_reg;
        exact_zero_next = exact_zero_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    lo_next    = in_ch.interval_low;
                    hi_next    = in_ch.interval_high;
                    sel_next   = SEL_LO;
                    start_next = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (ev_status.done)
                begin
                    case (sel_reg)
                        SEL_LO:
                        begin
                            sl_neg_next  = ev_status.neg;
                            sl_zero_next = ev_status.zero;
                            sel_next     = SEL_HI;
                            start_next   = 1'b1;
                        end
                        SEL_HI:
                        begin
                            sh_zero_next = ev_status.zero;
                            state_next   = ST_DECIDE;
                        end
                        default:
                        begin
                            sm_neg_next  = ev_status.neg;
                            sm_zero_next = ev_status.zero;
                            state_next   = ST_UPDATE;
                        end
                    endcase
                end
            end
            ST_DECIDE:
            begin
                if (finished)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        exact_zero_next = sl_zero_reg || sh_zero_reg;
                        if (sl_zero_reg)
                        begin
                            root_next = lo_reg;
                        end
                        else if (sh_zero_reg)
                        begin
                            root_next = hi_reg;
                        end
                        else
                        begin
                            root_next = mid_calc;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    mid_next   = mid_calc;
                    sel_next   = SEL_MID;
                    start_next = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_UPDATE:
            begin
                // keep the half that brackets the sign change
                if (opposite)
                begin
                    hi_next      = mid_reg;
                    sh_zero_next = sm_zero_reg;
                end
                else
                begin
                    lo_next      = mid_reg;
                    sl_neg_next  = sm_neg_reg;
                    sl_zero_next = sm_zero_reg;
                end
                state_next = ST_DECIDE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= SEL_LO;
            start_reg     <= 1'b0;
            sl_neg_reg    <= 1'b0;
            sl_zero_reg   <= 1'b0;
            sh_zero_reg   <= 1'b0;
            sm_neg_reg    <= 1'b0;
            sm_zero_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            start_reg     <= start_next;
            sl_neg_reg    <= sl_neg_next;
            sl_zero_reg   <= sl_zero_next;
            sh_zero_reg   <= sh_zero_next;
            sm_neg_reg    <= sm_neg_next;
            sm_zero_reg   <= sm_zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // interval and result registers
    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        root_reg       <= root_next;
        exact_zero_reg <= exact_zero_next;
    end

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.root       = root_reg;
    assign out_ch.exact_zero = exact_zero_reg;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import qbr_pkg::*;

    localparam int XW = X_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int CW = COEF_WIDTH_DEF;

    localparam int NUM_PHASES   = 31;
    localparam int PHASE_ITEMS  = 60;
    localparam int QUIET_PHASES = 3;
    localparam int HOLD_PHASE   = 4;
    localparam int LONG_HOLD    = 3000;
    localparam int MAX_HALVINGS = 200;
    // a little over one worst case search
    localparam int SETTLE       = 600;
    localparam int DRAIN_LIMIT  = 20000;

    typedef logic signed [XW-1:0] fix_t;
    typedef logic signed [CW-1:0] coef_t;

    typedef struct {
        fix_t lo;
        fix_t hi;
        bit   typed;
        fix_t root;
        bit   zero;
    } probe_t;

    typedef struct {
        fix_t root;
        bit   zero;
    } root_t;

    // coefficient sets for one phase
    typedef enum {
        SHAPE_FACTORED, SHAPE_LINEAR, SHAPE_RANDOM, SHAPE_ZERO, SHAPE_CONST,
        SHAPE_EXT_A, SHAPE_EXT_B
    } shape_e;

    // tolerance choices
    typedef enum {
        TOL_ZERO, TOL_ONE, TOL_RESET, TOL_SMALL, TOL_WIDE, TOL_FULL
    } tol_e;

    // interval shapes around a root candidate
    typedef enum {
        FORM_SPREAD, FORM_CENTERED, FORM_LEFT_AT, FORM_RIGHT_AT, FORM_NARROW,
        FORM_WILD, FORM_REVERSED, FORM_CORNER
    } form_e;

    localparam fix_t UNIT = fix_t'(64'sd1 <<< FB);
    localparam fix_t XMIN = {1'b1, {(XW-1){1'b0}}};
    localparam fix_t XMAX = {1'b0, {(XW-1){1'b1}}};
    localparam logic [XW-1:0] TOL_MAX = '1;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [XW-1:0] cfg_data;

    qbr_in_if  #(.X_WIDTH(XW)) in_ch ();
    qbr_out_if #(.X_WIDTH(XW)) out_ch ();

    quadratic_bisection_root_top #(
        .X_WIDTH   (XW),
        .FRAC_BITS (FB),
        .COEF_WIDTH(CW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // shadow copy of the block's registers
    coef_t c_const;
    coef_t c_lin;
    coef_t c_sq;
    logic [XW-1:0] tol_reg;

    root_t  pending_roots[$];
    probe_t probes[$];

    int n_err      = 0;
    int n_sent     = 0;
    int n_exact    = 0;
    int n_settings = 0;
    int hold_token = 0;
    bit idle_on    = 1'b0;

    always #10 clk = ~clk;

    // sign of q(x), evaluated exactly at 128 bits
    function automatic int poly_sign(fix_t x);
        logic signed [127:0] xw;
        logic signed [127:0] c0w;
        logic signed [127:0] c1w;
        logic signed [127:0] c2w;
        logic signed [127:0] acc;
        xw  = x;
        c0w = c_const;
        c1w = c_lin;
        c2w = c_sq;
        acc = (c0w <<< (2 * FB)) + ((c1w * xw) <<< FB) + c2w * xw * xw;
        if (acc < 0)
            return -1;
        if (acc == 0)
            return 0;
        return 1;
    endfunction

    // bisection search as the block should run it
    function automatic root_t find_root(fix_t lo_in, fix_t hi_in);
        fix_t lo;
        fix_t hi;
        fix_t mid;
        logic signed [XW:0] pair;
        logic signed [XW:0] span;
        logic [XW-1:0] tol;
        root_t r;
        int sl;
        int sm;
        int step;
        lo = lo_in;
        hi = hi_in;
        r.root = '0;
        r.zero = 1'b0;
        // zero tolerance behaves as one unit
        tol = (tol_reg == '0) ? XW'(1) : tol_reg;
        for (step = 0; step < MAX_HALVINGS; step++)
        begin
            sl = poly_sign(lo);
            if (sl == 0)
            begin
                r.root = lo;
                r.zero = 1'b1;
                return r;
            end
            if (poly_sign(hi) == 0)
            begin
                r.root = hi;
                r.zero = 1'b1;
                return r;
            end
            pair   = lo + hi;
            mid    = fix_t'(pair >>> 1);
            span   = hi - lo;
            r.root = mid;
            // reversed interval has negative span and stops here
            if (span <= $signed({1'b0, tol}))
                return r;
            sm = poly_sign(mid);
            if ((sl < 0 && sm > 0) || (sl > 0 && sm < 0))
                hi = mid;
            else
                lo = mid;
        end
        return r;
    endfunction

    function automatic fix_t rand_fix();
        return fix_t'({$urandom, $urandom});
    endfunction

    // offset of random magnitude, up to 41 bits
    function automatic fix_t rand_span();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return fix_t'(r >> $urandom_range(23, 63));
    endfunction

    function automatic coef_t rand_coef();
        case ($urandom_range(0, 4))
            0: return coef_t'(-32768);
            1: return coef_t'(32767);
            2: return coef_t'(0);
            default: return coef_t'($urandom);
        endcase
    endfunction

    function automatic fix_t pick_end(fix_t c);
        case ($urandom_range(0, 3))
            0: return XMIN;
            1: return XMAX;
            2: return fix_t'(0);
            default: return c;
        endcase
    endfunction

    task automatic add_probe(fix_t lo, fix_t hi, bit typed, fix_t root, bit zero);
        probe_t p;
        p.lo    = lo;
        p.hi    = hi;
        p.typed = typed;
        p.root  = root;
        p.zero  = zero;
        probes.push_back(p);
    endtask

    // register write, shadow copy follows after the edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [XW-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_COEF_CONST:  c_const = coef_t'(data[CW-1:0]);
            REG_COEF_LINEAR: c_lin   = coef_t'(data[CW-1:0]);
            REG_COEF_SQUARE: c_sq    = coef_t'(data[CW-1:0]);
            REG_TOLERANCE:   tol_reg = data;
            default: ;
        endcase
    endtask

    // offer one interval, record its root once the beat is taken
    task automatic send_item(fix_t lo, fix_t hi, bit typed, root_t want);
        in_ch.valid         <= 1'b1;
        in_ch.interval_low  <= lo;
        in_ch.interval_high <= hi;
        do @(posedge clk); while (!in_ch.ready);
        if (typed)
            pending_roots.push_back(want);
        else
            pending_roots.push_back(find_root(lo, hi));
        n_sent++;
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result side: check each beat, then decide next ready
    initial
    begin : result_side
        root_t want;
        int stall_left;
        int hold_seen;
        stall_left = 0;
        hold_seen  = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (pending_roots.size() == 0)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("tb: unexpected beat root %h exact_zero %b",
                                 out_ch.root, out_ch.exact_zero);
                end
                else
                begin
                    want = pending_roots.pop_front();
                    if (out_ch.root !== want.root || out_ch.exact_zero !== want.zero)
                    begin
                        n_err++;
                        if (n_err <= 10)
                            $display("tb: mismatch root exp %h got %h, exact_zero exp %b got %b",
                                     want.root, out_ch.root, want.zero, out_ch.exact_zero);
                    end
                    if (want.zero)
                        n_exact++;
                end
            end
            // long hold-off requested by the stimulus side
            if (hold_token != hold_seen)
            begin
                hold_seen  = hold_token;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(0, 16);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        root_t  want;
        shape_e shape;
        tol_e   tpick;
        form_e  form;
        fix_t   lo;
        fix_t   hi;
        fix_t   c;
        fix_t   d;
        fix_t   e;
        fix_t   ctr[2];
        coef_t  c0;
        coef_t  c1;
        coef_t  c2;
        logic [XW-1:0] tol;
        int k;
        int sg;
        int p;
        int q;
        int m;
        int ph;
        int it;
        int waited;

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= REG_COEF_CONST;
        cfg_data            <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.interval_low  <= '0;
        in_ch.interval_high <= '0;
        want.root = '0;
        want.zero = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at their reset values
        c_const = coef_t'(COEF_CONST_RST);
        c_lin   = coef_t'(COEF_LINEAR_RST);
        c_sq    = coef_t'(COEF_SQUARE_RST);
        tol_reg = XW'(TOLERANCE_RST);
        idle_on = 1'b1;

        // endpoint zeros, q = 3x^2 + 2x after reset
        add_probe(fix_t'(0), fix_t'(3) * UNIT, 1'b1, fix_t'(0), 1'b1);
        add_probe(fix_t'(5) * UNIT, fix_t'(0), 1'b1, fix_t'(0), 1'b1);
        add_probe(fix_t'(-1), fix_t'(0), 1'b1, fix_t'(0), 1'b1);
        // zero lands on the midpoint, next step flags it
        add_probe(-UNIT, UNIT, 1'b1, fix_t'(0), 1'b1);
        // reversed intervals return the midpoint at once
        add_probe(fix_t'(10), fix_t'(2), 1'b1, fix_t'(6), 1'b0);
        add_probe(XMAX, XMIN, 1'b1, fix_t'(-1), 1'b0);
        // already within tolerance
        add_probe(UNIT, UNIT + fix_t'(100), 1'b1, UNIT + fix_t'(50), 1'b0);
        add_probe(UNIT, UNIT + fix_t'(168), 1'b1, UNIT + fix_t'(84), 1'b0);
        add_probe(XMIN, XMIN, 1'b1, XMIN, 1'b0);
        add_probe(XMAX, XMAX, 1'b1, XMAX, 1'b0);
        // full searches
        add_probe(UNIT, UNIT + fix_t'(169), 1'b0, '0, 1'b0);
        add_probe(XMIN, XMAX, 1'b0, '0, 1'b0);
        add_probe(-UNIT, -(UNIT >>> 1), 1'b0, '0, 1'b0);
        add_probe(XMIN, UNIT, 1'b0, '0, 1'b0);
        add_probe(fix_t'(-5) * UNIT, fix_t'(7) * UNIT, 1'b0, '0, 1'b0);
        add_probe(fix_t'(44'hAAAAAAAAAAA), fix_t'(44'h55555555555), 1'b0, '0, 1'b0);
        add_probe(fix_t'(44'h55555555555), fix_t'(44'hAAAAAAAAAAA), 1'b0, '0, 1'b0);

        foreach (probes[i])
        begin
            sender_gap();
            want.root = probes[i].root;
            want.zero = probes[i].zero;
            send_item(probes[i].lo, probes[i].hi, probes[i].typed, want);
        end
        in_ch.valid <= 1'b0;
        wait_idle();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            idle_on = (ph < NUM_PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);

            // coefficient set, first phases pinned: factored, then the two extremes
            if (ph == 0)
                shape = SHAPE_FACTORED;
            else if (ph == 1)
                shape = SHAPE_EXT_A;
            else if (ph == 2)
                shape = SHAPE_EXT_B;
            else
                shape = shape_e'($urandom_range(0, 4));
            ctr[0] = fix_t'(0);
            ctr[1] = rand_fix() >>> $urandom_range(0, 43);
            sg = ($urandom_range(0, 1) == 0) ? 1 : -1;
            case (shape)
                SHAPE_FACTORED:
                begin
                    // roots at p/2 and q/2
                    k  = $urandom_range(1, 3);
                    p  = int'($urandom_range(0, 200)) - 100;
                    q  = int'($urandom_range(0, 200)) - 100;
                    c2 = coef_t'(4 * k * sg);
                    c1 = coef_t'(-2 * k * (p + q) * sg);
                    c0 = coef_t'(k * p * q * sg);
                    ctr[0] = fix_t'(longint'(p) <<< (FB - 1));
                    ctr[1] = fix_t'(longint'(q) <<< (FB - 1));
                end
                SHAPE_LINEAR:
                begin
                    m  = int'($urandom_range(0, 200)) - 100;
                    c2 = coef_t'(0);
                    c1 = coef_t'(int'($urandom_range(1, 300)) * sg);
                    c0 = coef_t'(-int'(c1) * m);
                    ctr[0] = fix_t'(longint'(m) <<< FB);
                end
                SHAPE_RANDOM:
                begin
                    c0 = rand_coef();
                    c1 = rand_coef();
                    c2 = rand_coef();
                end
                SHAPE_ZERO:
                begin
                    c0 = coef_t'(0);
                    c1 = coef_t'(0);
                    c2 = coef_t'(0);
                end
                SHAPE_CONST:
                begin
                    c0 = coef_t'(int'($urandom_range(1, 32767)) * sg);
                    c1 = coef_t'(0);
                    c2 = coef_t'(0);
                end
                SHAPE_EXT_A:
                begin
                    c0 = coef_t'(-32768);
                    c1 = coef_t'(32767);
                    c2 = coef_t'(-32768);
                    ctr[1] = UNIT;
                end
                default:
                begin
                    c0 = coef_t'(32767);
                    c1 = coef_t'(-32768);
                    c2 = coef_t'(32767);
                    ctr[1] = -UNIT;
                end
            endcase

            if (ph == 0)
                tpick = TOL_ZERO;
            else if (ph == 1)
                tpick = TOL_FULL;
            else if (ph == 2)
                tpick = TOL_ONE;
            else
                tpick = tol_e'($urandom_range(0, 5));
            case (tpick)
                TOL_ZERO:  tol = '0;
                TOL_ONE:   tol = XW'(1);
                TOL_RESET: tol = XW'(TOLERANCE_RST);
                TOL_SMALL: tol = XW'($urandom_range(2, 4095));
                TOL_WIDE:  tol = XW'({$urandom, $urandom});
                default:   tol = TOL_MAX;
            endcase

            write_reg(REG_COEF_CONST, fix_t'(c0));
            write_reg(REG_COEF_LINEAR, fix_t'(c1));
            write_reg(REG_COEF_SQUARE, fix_t'(c2));
            write_reg(REG_TOLERANCE, tol);
            cfg_we <= 1'b0;
            n_settings++;

            // receiver holds off while intervals keep coming
            if (ph == HOLD_PHASE)
                hold_token++;

            for (it = 0; it < PHASE_ITEMS; it++)
            begin
                sender_gap();
                c    = ctr[$urandom_range(0, 1)];
                d    = rand_span();
                e    = rand_span();
                form = form_e'($urandom_range(0, 7));
                case (form)
                    FORM_SPREAD:
                    begin
                        lo = c - d;
                        hi = c + e;
                    end
                    FORM_CENTERED:
                    begin
                        lo = c - d;
                        hi = c + d;
                    end
                    FORM_LEFT_AT:
                    begin
                        lo = c;
                        hi = c + d;
                    end
                    FORM_RIGHT_AT:
                    begin
                        lo = c - d;
                        hi = c;
                    end
                    FORM_NARROW:
                    begin
                        lo = c - (d >>> 20);
                        hi = lo + fix_t'($urandom_range(0, 400));
                    end
                    FORM_WILD:
                    begin
                        lo = rand_fix();
                        hi = rand_fix();
                    end
                    FORM_REVERSED:
                    begin
                        lo = c + d;
                        hi = c - e;
                    end
                    default:
                    begin
                        lo = pick_end(c);
                        hi = pick_end(c);
                    end
                endcase
                send_item(lo, hi, 1'b0, want);
            end
            in_ch.valid <= 1'b0;
            wait_idle();
        end

        // drain, then watch for stray beats
        waited = 0;
        while (pending_roots.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
        if (pending_roots.size() != 0)
        begin
            n_err += pending_roots.size();
            $display("tb: %0d roots never came out", pending_roots.size());
        end

        $display("tb: searched %0d intervals under %0d register settings",
                 n_sent, n_settings);
        $display("tb: %0d results flagged an exact zero, %0d failures", n_exact, n_err);
        if (n_err == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // hard stop well past the slowest correct run
    initial
    begin : watchdog
        #(200_000_000);
        $display("tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
design/qbr_pkg.sv
design/qbr_if.sv
design/qbr_quad_eval.sv
design/quadratic_bisection_root_top.sv
sim/tb.sv
